// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// The macros expect signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ===== sv/prt_pkg.sv =====
// Package of the packet reassembly tracker: word types, codes and constants.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package prt_pkg;

	localparam int unsigned HDR_BYTES      = 6;
	localparam int unsigned POS_W          = 17;
	localparam logic [POS_W-1:0] POS_MAX   = '1;
	localparam int unsigned FIFO_DEPTH_DEF = 4;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_LENGTH    = 2'd1;
	localparam logic [1:0] ERR_ID_CHANGE = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic        accepted;
		logic        message_done;
		logic [1:0]  error_code;
		logic [15:0] message_id;
		logic [15:0] message_size;
		logic [15:0] packet_count;
		logic [15:0] bytes_collected;
	} out_word_t;

	// Summary of one finished buffer, passed from the parser to the tracker.
	typedef struct packed {
		logic        len_ok;
		logic [15:0] id;
		logic [15:0] msize;
		logic [15:0] dsize;
	} buf_summary_t;

endpackage

// ===== sv/prt_front.sv =====
// Byte parser: gathers the six-byte header and the buffer length, checks the length.
// Depends on prt_pkg; pushes one buf_summary_t per buffer into the queue.
`timescale 1ns / 1ps

module prt_front import prt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  in_word_t     in_data,
	input  logic         fifo_full,
	output logic         push_valid,
	output buf_summary_t push_data
);

	logic [POS_W-1:0] pos_q;
	logic [47:0]      hdr_q;
	logic [47:0]      hdr_n;
	logic [POS_W-1:0] count;
	logic             accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		hdr_n = hdr_q;
		if (pos_q < POS_W'(HDR_BYTES)) begin
			hdr_n[{pos_q[2:0], 3'b000} +: 8] = in_data.data_byte;
		end
		count = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	end

	always_comb begin
		push_data.id     = hdr_n[15:0];
		push_data.msize  = hdr_n[31:16];
		push_data.dsize  = hdr_n[47:32];
		push_data.len_ok = (count >= POS_W'(HDR_BYTES)) &&
			({1'b0, hdr_n[47:32]} == count - POS_W'(HDR_BYTES));
		push_valid = accept && in_data.last_of_buffer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
		end else if (accept) begin
			if (in_data.last_of_buffer) begin
				pos_q <= '0;
				hdr_q <= '0;
			end else begin
				pos_q <= count;
				hdr_q <= hdr_n;
			end
		end
	end

endmodule

// ===== sv/prt_fifo.sv =====
// Short show-ahead queue of buffer summaries between the parser and the tracker.
// Depends on prt_pkg for buf_summary_t.
`timescale 1ns / 1ps

module prt_fifo import prt_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  buf_summary_t push_data,
	output logic         full,
	output logic         pop_valid,
	output buf_summary_t pop_data,
	input  logic         pop
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	buf_summary_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/prt_back.sv =====
// Message tracker: applies each buffer summary to the pending message state
// and drives the registered result word. Depends on prt_pkg.
`timescale 1ns / 1ps

module prt_back import prt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         sum_valid,
	input  buf_summary_t sum_data,
	output logic         sum_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output out_word_t    out_data
);

	logic        clear_on_error_q;
	logic        have_pending_q;
	logic [15:0] pending_id_q;
	logic [15:0] pending_size_q;
	logic [15:0] total_q;
	logic [15:0] packets_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic        have_n;
	logic [15:0] pid_n;
	logic [15:0] psize_n;
	logic [15:0] total_n;
	logic [15:0] packets_n;
	out_word_t   res;

	logic        id_change;
	logic [15:0] base_total;
	logic [15:0] base_packets;
	logic [15:0] sum_total;
	logic [15:0] sum_packets;

	assign sum_pop   = sum_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		id_change    = have_pending_q && (sum_data.id != pending_id_q);
		// A changed id restarts the message from an empty count.
		base_total   = id_change ? 16'd0 : total_q;
		base_packets = id_change ? 16'd0 : packets_q;
		sum_total    = base_total + sum_data.dsize;
		sum_packets  = (base_packets == 16'hFFFF) ? base_packets : base_packets + 16'd1;

		have_n    = have_pending_q;
		pid_n     = pending_id_q;
		psize_n   = pending_size_q;
		total_n   = total_q;
		packets_n = packets_q;
		res       = '0;

		if (!sum_data.len_ok) begin
			res.error_code = ERR_LENGTH;
			if (clear_on_error_q) begin
				have_n    = 1'b0;
				total_n   = '0;
				packets_n = '0;
			end
		end else if (id_change && (sum_data.msize == total_q)) begin
			// The new buffer closes the old message out and is itself discarded.
			res.accepted     = 1'b1;
			res.message_done = 1'b1;
			res.message_id   = pending_id_q;
			res.message_size = pending_size_q;
			res.packet_count = packets_q;
			have_n    = 1'b0;
			total_n   = '0;
			packets_n = '0;
		end else begin
			res.accepted   = !id_change;
			res.error_code = id_change ? ERR_ID_CHANGE : ERR_NONE;
			have_n    = 1'b1;
			pid_n     = sum_data.id;
			psize_n   = sum_data.msize;
			total_n   = sum_total;
			packets_n = sum_packets;
			if (sum_total == sum_data.msize) begin
				res.message_done = 1'b1;
				res.message_id   = sum_data.id;
				res.message_size = sum_data.msize;
				res.packet_count = sum_packets;
				have_n    = 1'b0;
				total_n   = '0;
				packets_n = '0;
			end
		end
		res.bytes_collected = total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_on_error_q <= 1'b1;
		end else if (cfg_we) begin
			clear_on_error_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pending_q <= 1'b0;
			pending_id_q   <= '0;
			pending_size_q <= '0;
			total_q        <= '0;
			packets_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (sum_pop) begin
				have_pending_q <= have_n;
				pending_id_q   <= pid_n;
				pending_size_q <= psize_n;
				total_q        <= total_n;
				packets_q      <= packets_n;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_pop) begin
			out_q <= res;
		end
	end

endmodule

// ===== sv/packet_reassembly_tracker_core.sv =====
// Packet reassembly tracker: one byte word accepted per cycle unless the
// summary queue is full; a buffer's result word is registered by the tracker.
// Parser, queue and tracker each take one step per cycle unless stalled.
// Reset (arst_n, asynchronous) empties the queue, clears all message state
// and sets clear_on_error to 1.
`timescale 1ns / 1ps

module packet_reassembly_tracker_core import prt_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic         push_valid;
	buf_summary_t push_data;
	logic         fifo_full;
	logic         sum_valid;
	buf_summary_t sum_data;
	logic         sum_pop;

	prt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.fifo_full  (fifo_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	prt_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (fifo_full),
		.pop_valid  (sum_valid),
		.pop_data   (sum_data),
		.pop        (sum_pop)
	);

	prt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sum_valid (sum_valid),
		.sum_data  (sum_data),
		.sum_pop   (sum_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sv/prt_checker.sv =====
// Port-level checker of the packet reassembly tracker and its bind to the top level.
// Depends on prt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prt_checker import prt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_we,
	input logic      cfg_wdata,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// A stalled result word holds.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// Message fields stay zero unless a message completes.
	`ASSERT_IMPL(a_idle_fields, out_valid && !out_data.message_done,
		out_data.message_id == 16'd0 && out_data.message_size == 16'd0 &&
		out_data.packet_count == 16'd0)
	// A completed message leaves nothing pending.
	`ASSERT_IMPL(a_done_clears, out_valid && out_data.message_done,
		out_data.bytes_collected == 16'd0 && out_data.packet_count != 16'd0)
	// An accepted word carries no error; a length failure completes nothing.
	`ASSERT_IMPL(a_accept_err, out_valid && out_data.accepted,
		out_data.error_code == ERR_NONE)
	`ASSERT_IMPL(a_len_fail, out_valid && out_data.error_code == ERR_LENGTH,
		!out_data.accepted && !out_data.message_done)

endmodule

bind packet_reassembly_tracker_core prt_checker u_prt_checker (.*);
